// ===== src/p4212_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// P4212 asymmetric unit reduction: shared types and constants
// Widths of the index and phase fields, the per-stage pipeline record and
// the operator codes used by the settling stages.
// ----------------------------------------------------------------------------
package p4212_pkg;

  // Width of the index fields at the ports.
  localparam int IDX_W = 8;
  // Internal index width: one bit of headroom so that -128 can be negated.
  localparam int W = IDX_W + 1;
  // Width of the phase offset field.
  localparam int OFF_W = 19;
  // Number of unrolled settling iterations, one per pipeline stage.
  localparam int NUM_ITER = 8;
  // Running sum of (h + k) over k-flips; at most NUM_ITER terms of 2^W each.
  localparam int SUM_W = W + $clog2(NUM_ITER) + 1;
  // Pass counter value at which the triple is settled.
  localparam logic [1:0] PASS_DONE = 2'd2;

  // Operator applied by one settling iteration.
  typedef enum logic [1:0] {
    OP_KFLIP,
    OP_SWAPNEG,
    OP_SWAP,
    OP_SETTLE
  } op_t;

  // Working state of one item as it moves through the pipeline.
  typedef struct packed {
    logic signed [W-1:0]     h;
    logic signed [W-1:0]     k;
    logic signed [W-1:0]     l;
    logic                    neg;
    logic signed [SUM_W-1:0] sum;
    logic [1:0]              pass;
  } stage_t;

endpackage
`default_nettype wire

// ===== src/p4212_asymmetric_unit_reduce_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// P4212 asymmetric unit reduction core
// Maps a reflection index triple into the P4212 asymmetric unit and reports
// the phase sign, the unreduced phase offset and the special-phase flags.
// ----------------------------------------------------------------------------
// Pipeline: input conjugation stage, eight settling stages, output stage;
// done is registered alongside the output stage.
// Throughput: one item per cycle; busy is held low, each settling iteration
// has a pipeline stage of its own.
// Reset: rst clears the valid bits of every stage and the done strobe.
// The receiver cannot stall, so the pipeline never holds.
module p4212_asymmetric_unit_reduce_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [p4212_pkg::IDX_W-1:0] h_in,
  input  wire logic signed [p4212_pkg::IDX_W-1:0] k_in,
  input  wire logic signed [p4212_pkg::IDX_W-1:0] l_in,
  output logic                                    done,
  output logic signed [p4212_pkg::IDX_W-1:0]      h_out,
  output logic signed [p4212_pkg::IDX_W-1:0]      k_out,
  output logic signed [p4212_pkg::IDX_W-1:0]      l_out,
  output logic                                    phase_negate,
  output logic signed [p4212_pkg::OFF_W-1:0]      phase_offset,
  output logic                                    is_special,
  output logic                                    is_imaginary
);
  import p4212_pkg::*;

  // Negate all three indices and flip the phase sign.
  function automatic stage_t conjugate(input stage_t s);
    stage_t t;
    t     = s;
    t.h   = -s.h;
    t.k   = -s.k;
    t.l   = -s.l;
    t.neg = !s.neg;
    return t;
  endfunction

  // One settling iteration: classify, apply one operator, count passes.
  function automatic stage_t iter_step(input stage_t s);
    stage_t              t;
    logic signed [W-1:0] ak;
    logic [2:0]          cls;
    op_t                 op;
    t   = s;
    ak  = s.k[W-1] ? -s.k : s.k;
    cls = {(s.h < ak), !s.l[W-1], !s.k[W-1]};
    unique case (cls) inside
      3'b111:         op = OP_SETTLE;
      3'b011:         op = OP_SWAP;
      3'b001, 3'b101: op = OP_SWAPNEG;
      default:        op = OP_KFLIP;
    endcase
    if (s.pass != PASS_DONE) begin
      unique case (op)
        OP_KFLIP: begin
          // New k is -k, so the offset term h' + k' is h - k.
          t.k   = -s.k;
          t.neg = !s.neg;
          t.sum = s.sum + SUM_W'(s.h) - SUM_W'(s.k);
        end
        OP_SWAPNEG: begin
          t.h = s.k;
          t.k = s.h;
          t.l = -s.l;
        end
        OP_SWAP: begin
          t.h   = s.k;
          t.k   = s.h;
          t.neg = !s.neg;
        end
        default: begin
        end
      endcase
      // A swap or a settled class closes one pass.
      if (op == OP_SWAP || op == OP_SETTLE) begin
        if (t.h == '0 && t.k[W-1]) begin
          t = conjugate(t);
        end
        t.pass = t.pass + 2'd1;
      end
    end
    return t;
  endfunction

  stage_t              in_rec;
  stage_t              stg [NUM_ITER+1];
  logic [NUM_ITER:0]   vld;
  logic                accept;
  stage_t              fin;
  logic signed [W:0]   hk_sum;
  logic signed [OFF_W-1:0] sum_ext;

  // The pipeline never stalls, so an item is taken whenever start is high.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Input record with conjugate symmetry applied where needed.
  always_comb begin
    in_rec.h    = W'(h_in);
    in_rec.k    = W'(k_in);
    in_rec.l    = W'(l_in);
    in_rec.neg  = 1'b0;
    in_rec.sum  = '0;
    in_rec.pass = '0;
    if (h_in < 0 || (h_in == 0 && k_in < 0) || (h_in == 0 && k_in == 0 && l_in < 0)) begin
      in_rec = conjugate(in_rec);
    end
  end

  // Valid bits travel alongside the stage records.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[NUM_ITER-1:0], accept};
      done <= vld[NUM_ITER];
    end
  end

  // Stage records: conjugation stage, then one settling iteration per stage.
  always_ff @(posedge clk) begin
    stg[0] <= in_rec;
    for (int i = 0; i < NUM_ITER; i++) begin
      stg[i+1] <= iter_step(stg[i]);
    end
  end

  // Final stage: special-phase flags and offset scaling by 180.
  assign fin     = stg[NUM_ITER];
  assign hk_sum  = (W+1)'(fin.h) + (W+1)'(fin.k);
  assign sum_ext = OFF_W'(fin.sum);

  always_ff @(posedge clk) begin
    h_out        <= fin.h[IDX_W-1:0];
    k_out        <= fin.k[IDX_W-1:0];
    l_out        <= fin.l[IDX_W-1:0];
    phase_negate <= fin.neg;
    // 180 = 128 + 32 + 16 + 4; the field wraps like the unreduced offset.
    phase_offset <= (sum_ext <<< 7) + (sum_ext <<< 5) + (sum_ext <<< 4) + (sum_ext <<< 2);
    if (fin.h == '0 || fin.k == '0) begin
      is_special   <= 1'b1;
      is_imaginary <= (hk_sum > 0) && hk_sum[0];
    end else begin
      is_special   <= (fin.l == '0) || (fin.h == fin.k);
      is_imaginary <= 1'b0;
    end
  end

  // Every item has finished both passes by the last settling stage.
  a_settled: assert property (@(posedge clk) disable iff (rst)
    vld[NUM_ITER] |-> (stg[NUM_ITER].pass == PASS_DONE))
    else $error("item left the settling stages unsettled");

  // A settled triple lies in the unit: h, k, l non-negative and h <= k.
  a_in_unit: assert property (@(posedge clk) disable iff (rst)
    vld[NUM_ITER] |-> (!stg[NUM_ITER].h[W-1] && !stg[NUM_ITER].k[W-1] &&
                       !stg[NUM_ITER].l[W-1] && (stg[NUM_ITER].h <= stg[NUM_ITER].k)))
    else $error("settled triple outside the asymmetric unit");

  // An imaginary phase is only ever reported for a special reflection.
  a_imag_special: assert property (@(posedge clk) disable iff (rst)
    (done && is_imaginary) |-> is_special)
    else $error("imaginary flag without special flag");

endmodule
`default_nettype wire

// ===== tb/p4212_asymmetric_unit_reduce_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// P4212 asymmetric unit reduction core testbench
// Sends reflection index triples through the core and compares every result
// with a software reduction of the same triple. The run covers the index
// extremes, every class of settling step, the special-phase cases, and long
// random streams both with random input gaps and back to back.
// ----------------------------------------------------------------------------
module p4212_asymmetric_unit_reduce_core_tb;
  import p4212_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 11;
  localparam int PIPE_LATENCY = 10;
  localparam int MAX_GAP      = 9;
  localparam int DRAIN_LIMIT  = 1000;

  // One reduced reflection as it appears on the result ports.
  typedef struct {
    logic signed [IDX_W-1:0] h;
    logic signed [IDX_W-1:0] k;
    logic signed [IDX_W-1:0] l;
    logic                    neg;
    logic signed [OFF_W-1:0] off;
    logic                    special;
    logic                    imag;
  } asu_result_t;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic signed [IDX_W-1:0] h_in;
  logic signed [IDX_W-1:0] k_in;
  logic signed [IDX_W-1:0] l_in;
  logic                    done;
  logic signed [IDX_W-1:0] h_out;
  logic signed [IDX_W-1:0] k_out;
  logic signed [IDX_W-1:0] l_out;
  logic                    phase_negate;
  logic signed [OFF_W-1:0] phase_offset;
  logic                    is_special;
  logic                    is_imaginary;

  asu_result_t expected_asu[$];
  int          mismatch_count = 0;
  int          gap_limit      = MAX_GAP;

  p4212_asymmetric_unit_reduce_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .h_in         (h_in),
    .k_in         (k_in),
    .l_in         (l_in),
    .done         (done),
    .h_out        (h_out),
    .k_out        (k_out),
    .l_out        (l_out),
    .phase_negate (phase_negate),
    .phase_offset (phase_offset),
    .is_special   (is_special),
    .is_imaginary (is_imaginary)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the core hangs.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Reduces one triple into the asymmetric unit, with full integer headroom.
  function automatic asu_result_t reduce_to_asu(input logic signed [IDX_W-1:0] hi,
                                                input logic signed [IDX_W-1:0] ki,
                                                input logic signed [IDX_W-1:0] li);
    asu_result_t r;
    int          h;
    int          k;
    int          l;
    int          off;
    int          tmp;
    int          cls;
    int          passes;
    int          sum;
    bit          neg;
    op_t         op;
    h      = int'(hi);
    k      = int'(ki);
    l      = int'(li);
    off    = 0;
    neg    = 1'b0;
    passes = 0;
    // Friedel mate first when the triple lies in the negative half.
    if (h < 0 || (h == 0 && k < 0) || (h == 0 && k == 0 && l < 0)) begin
      h   = -h;
      k   = -k;
      l   = -l;
      neg = !neg;
    end
    for (int it = 0; it < NUM_ITER && passes < PASS_DONE; it++) begin
      cls = (k >= 0 ? 1 : 0) + (l >= 0 ? 2 : 0) + (h < (k < 0 ? -k : k) ? 4 : 0);
      case (cls)
        0, 2, 4, 6: op = OP_KFLIP;
        1, 5:       op = OP_SWAPNEG;
        3:          op = OP_SWAP;
        default:    op = OP_SETTLE;
      endcase
      case (op)
        OP_KFLIP: begin
          k   = -k;
          neg = !neg;
          off = off + 180 * (h + k);
        end
        OP_SWAPNEG: begin
          tmp = h;
          h   = k;
          k   = tmp;
          l   = -l;
        end
        OP_SWAP: begin
          tmp = h;
          h   = k;
          k   = tmp;
          neg = !neg;
        end
        default: ;
      endcase
      // A swap or a settled class closes one pass.
      if (op == OP_SWAP || op == OP_SETTLE) begin
        if (h == 0 && k < 0) begin
          h   = -h;
          k   = -k;
          l   = -l;
          neg = !neg;
        end
        passes++;
      end
    end
    r.special = 1'b0;
    r.imag    = 1'b0;
    if (h == 0 || k == 0) begin
      sum       = h + k;
      r.special = 1'b1;
      r.imag    = (sum > 0) && (sum % 2 != 0);
    end else if (l == 0 || h == k) begin
      r.special = 1'b1;
    end
    r.h   = h[IDX_W-1:0];
    r.k   = k[IDX_W-1:0];
    r.l   = l[IDX_W-1:0];
    r.neg = neg;
    r.off = off[OFF_W-1:0];
    return r;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Sends one triple after a random gap and queues its expected reduction.
  task automatic send_triple(input logic signed [IDX_W-1:0] h,
                             input logic signed [IDX_W-1:0] k,
                             input logic signed [IDX_W-1:0] l);
    int gap;
    gap = (gap_limit == 0) ? 0 : $urandom_range(gap_limit, 0);
    if (gap > 0) begin
      // Junk on the index pins while start is low must be ignored.
      start <= 1'b0;
      h_in  <= IDX_W'($urandom);
      k_in  <= IDX_W'($urandom);
      l_in  <= IDX_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    h_in  <= h;
    k_in  <= k;
    l_in  <= l;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_asu.push_back(reduce_to_asu(h, k, l));
  endtask

  // Draws one index, weighted toward the extremes and zero.
  function automatic logic signed [IDX_W-1:0] draw_index(input bit narrow);
    case ($urandom_range(9, 0))
      0:       return -8'sd128;
      1:       return 8'sd127;
      2:       return -8'sd127;
      3:       return 8'sd0;
      default: return narrow ? IDX_W'($urandom_range(8, 0) - 4) : IDX_W'($urandom_range(255, 0));
    endcase
  endfunction

  // Every result is compared with the oldest expectation.
  always @(posedge clk) begin : check_results
    asu_result_t want;
    if (!rst && done) begin
      if (expected_asu.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = expected_asu.pop_front();
        if (h_out !== want.h) report_mismatch("h_out", h_out, want.h);
        if (k_out !== want.k) report_mismatch("k_out", k_out, want.k);
        if (l_out !== want.l) report_mismatch("l_out", l_out, want.l);
        if (phase_negate !== want.neg) report_mismatch("phase_negate", phase_negate, want.neg);
        if (phase_offset !== want.off) report_mismatch("phase_offset", phase_offset, want.off);
        if (is_special !== want.special) report_mismatch("is_special", is_special, want.special);
        if (is_imaginary !== want.imag) report_mismatch("is_imaginary", is_imaginary, want.imag);
      end
    end
  end

  // Largest and smallest indices, including the out-of-range -128.
  task automatic test_index_extremes();
    send_triple(8'sd127, 8'sd127, 8'sd127);
    send_triple(-8'sd127, -8'sd127, -8'sd127);
    send_triple(-8'sd128, -8'sd128, -8'sd128);
    send_triple(8'sd127, -8'sd128, 8'sd0);
    send_triple(-8'sd128, 8'sd127, -8'sd1);
    send_triple(8'sd0, 8'sd0, -8'sd128);
    send_triple(8'sd0, -8'sd128, 8'sd5);
    send_triple(-8'sd128, 8'sd0, 8'sd0);
    send_triple(8'sd127, -8'sd127, 8'sd127);
  endtask

  // Conjugation cases, every settling class and the special phases.
  task automatic test_special_cases();
    send_triple(8'sd0, 8'sd0, 8'sd0);
    send_triple(8'sd0, 8'sd0, -8'sd7);
    send_triple(8'sd0, -8'sd6, 8'sd3);
    send_triple(-8'sd4, 8'sd2, 8'sd9);
    send_triple(8'sd5, 8'sd5, 8'sd5);
    send_triple(8'sd5, 8'sd5, -8'sd5);
    send_triple(8'sd3, 8'sd8, 8'sd0);
    send_triple(8'sd0, 8'sd3, 8'sd2);
    send_triple(8'sd3, 8'sd0, 8'sd2);
    send_triple(8'sd2, -8'sd9, -8'sd4);
    send_triple(8'sd9, -8'sd2, -8'sd4);
    send_triple(-8'sd6, -8'sd6, 8'sd3);
    send_triple(8'sd4, -8'sd4, 8'sd4);
    send_triple(8'sd1, 8'sd0, -8'sd1);
  endtask

  // Random triples over the whole index range, with random gaps.
  task automatic test_random_wide(input int count);
    for (int i = 0; i < count; i++)
      send_triple(draw_index(1'b0), draw_index(1'b0), draw_index(1'b0));
  endtask

  // Small random triples, often with |h| = |k|, to hit the special phases.
  task automatic test_random_small(input int count);
    logic signed [IDX_W-1:0] h;
    logic signed [IDX_W-1:0] k;
    for (int i = 0; i < count; i++) begin
      h = draw_index(1'b1);
      k = draw_index(1'b1);
      case ($urandom_range(3, 0))
        0:       k = h;
        1:       k = -h;
        default: ;
      endcase
      send_triple(h, k, draw_index(1'b1));
    end
  endtask

  // A stretch with start held high for every cycle.
  task automatic test_back_to_back(input int count);
    gap_limit = 0;
    for (int i = 0; i < count; i++)
      send_triple(draw_index(1'($urandom_range(1, 0))), draw_index(1'($urandom_range(1, 0))),
                  draw_index(1'($urandom_range(1, 0))));
    gap_limit = MAX_GAP;
  endtask

  // Reset, test sequence and final verdict.
  initial begin
    int waited;
    rst   = 1'b1;
    start = 1'b0;
    h_in  = '0;
    k_in  = '0;
    l_in  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_index_extremes();
    test_special_cases();
    test_random_wide(300);
    test_back_to_back(150);
    test_random_small(250);
    test_back_to_back(50);
    test_random_wide(100);
    start <= 1'b0;

    // Drain the pipeline, then allow a little extra for stray strobes.
    waited = 0;
    while (expected_asu.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk);
    if (expected_asu.size() != 0)
      report_mismatch("missing items", 0, expected_asu.size());

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
